// ===== rtl/gf2pt_pkg.sv =====
// shared types, constants and helpers for the gf2 degree-64 primitivity test unit
`default_nettype none

package gf2pt_pkg;

    localparam int WORD_W     = 64;
    localparam int DIGIT_W_DEF = 8;
    localparam int NUM_Q      = 7;
    localparam int Q_IDX_W    = 3;
    localparam int BIT_IDX_W  = 6;
    localparam int K_W        = 7;

    localparam logic [1:0] VERDICT_REDUCIBLE   = 2'd0;
    localparam logic [1:0] VERDICT_IRREDUCIBLE = 2'd1;
    localparam logic [1:0] VERDICT_PRIMITIVE   = 2'd2;

    localparam logic [WORD_W-1:0] POLY_ONE = 64'h0000_0000_0000_0001;
    localparam logic [WORD_W-1:0] POLY_X   = 64'h0000_0000_0000_0002;
    localparam logic [K_W-1:0]    K_LAST   = 7'd64;
    localparam logic [Q_IDX_W-1:0] Q_LAST  = 3'd6;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_IRR_GO,
        ST_IRR_WAIT,
        ST_POW_SQ,
        ST_POW_SQ_WAIT,
        ST_POW_X,
        ST_DONE
    } t_state;

    // multiply by x and fold the x^64 term back in with the tail
    function automatic logic [WORD_W-1:0] gf_mulx(input logic [WORD_W-1:0] v,
                                                  input logic [WORD_W-1:0] tail);
        gf_mulx = {v[WORD_W-2:0], 1'b0} ^ (v[WORD_W-1] ? tail : '0);
    endfunction

    // (2^64-1)/q for the seven prime factors of 2^64-1
    function automatic logic [WORD_W-1:0] pow_exp(input logic [Q_IDX_W-1:0] idx);
        case (idx)
            3'd0:    pow_exp = 64'h5555_5555_5555_5555;
            3'd1:    pow_exp = 64'h3333_3333_3333_3333;
            3'd2:    pow_exp = 64'h0F0F_0F0F_0F0F_0F0F;
            3'd3:    pow_exp = 64'h00FF_00FF_00FF_00FF;
            3'd4:    pow_exp = 64'h0066_3D80_FF99_C27F;
            3'd5:    pow_exp = 64'h0000_FFFF_0000_FFFF;
            3'd6:    pow_exp = 64'h0000_0280_FFFF_FD7F;
            default: pow_exp = '0;
        endcase
    endfunction

endpackage

`default_nettype wire

// ===== rtl/gf2pt_mul.sv =====
// digit-serial modular multiplier over gf(2)[x]/(x^64 + tail)
`default_nettype none

module gf2pt_mul #(
    parameter int DIGIT_W = gf2pt_pkg::DIGIT_W_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic [gf2pt_pkg::WORD_W-1:0]  i_a,
    input  wire logic [gf2pt_pkg::WORD_W-1:0]  i_b,
    input  wire logic [gf2pt_pkg::WORD_W-1:0]  i_tail,
    output logic                               o_done,
    output logic [gf2pt_pkg::WORD_W-1:0]       o_result
);
    import gf2pt_pkg::*;

    localparam int STEPS = WORD_W / DIGIT_W;
    localparam int CNT_W = (STEPS > 1) ? $clog2(STEPS) : 1;

    logic              r_run;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [WORD_W-1:0] r_acc;
    logic [WORD_W-1:0] r_a;
    logic [WORD_W-1:0] r_b;
    logic [WORD_W-1:0] r_tail;
    logic [WORD_W-1:0] n_acc;

    // msb-first horner step over one digit of b
    always_comb begin
        n_acc = r_acc;
        for (int j = 0; j < DIGIT_W; j++) begin
            n_acc = gf_mulx(n_acc, r_tail) ^ (r_b[WORD_W-1-j] ? r_a : '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
                r_cnt <= '0;
            end else if (r_run) begin
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(STEPS - 1)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_acc  <= '0;
            r_a    <= i_a;
            r_b    <= i_b;
            r_tail <= i_tail;
        end else if (r_run) begin
            r_acc <= n_acc;
            r_b   <= r_b << DIGIT_W;
        end
    end

    assign o_done   = r_done;
    assign o_result = r_acc;

endmodule

`default_nettype wire

// ===== rtl/gf2_poly64_primitivity_test_unit.sv =====
// top level: sequencer for irreducibility and primitivity checks over one shared multiplier
// each product runs in the multiplier between an issue state and the write-back of its result;
// the verdict strobe comes soonest at the earliest reducible exit, later after all 64 squarings
// and latest for a primitive candidate; one candidate at a time, start taken only while busy is
// low; the verdict strobe lasts one cycle and cannot be stalled; synchronous active-low reset
`default_nettype none

module gf2_poly64_primitivity_test_unit #(
    parameter int DIGIT_W = gf2pt_pkg::DIGIT_W_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [gf2pt_pkg::WORD_W-1:0]  i_candidate_low,
    output logic                               o_valid,
    output logic [1:0]                         o_verdict
);
    import gf2pt_pkg::*;

    t_state                r_state;
    t_state                n_state;
    logic [WORD_W-1:0]     r_tail;
    logic [WORD_W-1:0]     r_v;
    logic [WORD_W-1:0]     n_v;
    logic [K_W-1:0]        r_k;
    logic [Q_IDX_W-1:0]    r_qi;
    logic [BIT_IDX_W-1:0]  r_bit;
    logic [1:0]            r_verdict;
    logic [1:0]            n_verdict;

    logic                  mul_start;
    logic                  mul_done;
    logic [WORD_W-1:0]     mul_result;
    logic [WORD_W-1:0]     exp_word;
    logic                  irr_fail;
    logic                  irr_pass;
    logic                  pow_last;

    gf2pt_mul #(
        .DIGIT_W (DIGIT_W)
    ) u_mul (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (mul_start),
        .i_a      (r_v),
        .i_b      (r_v),
        .i_tail   (r_tail),
        .o_done   (mul_done),
        .o_result (mul_result)
    );

    assign exp_word = pow_exp(r_qi);

    // x^(2^k) back at x for a proper divisor k of 64, or not at x after 64 squarings
    assign irr_fail = (r_k == K_LAST) ? (mul_result != POLY_X)
                                      : ($onehot(r_k) && (mul_result == POLY_X));
    assign irr_pass = (r_k == K_LAST) && (mul_result == POLY_X);

    // take the product in the wait states; in the power phase multiply by x only where the exponent bit is set
    always_comb begin
        n_v = r_v;
        case (r_state)
            ST_IRR_WAIT,
            ST_POW_SQ_WAIT: begin
                if (mul_done) begin
                    n_v = mul_result;
                end
            end
            ST_POW_X: begin
                if (exp_word[r_bit]) begin
                    n_v = gf_mulx(r_v, r_tail);
                end
            end
            default: begin
                n_v = r_v;
            end
        endcase
    end

    assign pow_last = (r_bit == '0);

    // next state
    always_comb begin
        n_state   = r_state;
        n_verdict = r_verdict;
        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_state = ST_IRR_GO;
                end
            end
            ST_IRR_GO: begin
                n_state = ST_IRR_WAIT;
            end
            ST_IRR_WAIT: begin
                if (mul_done) begin
                    if (irr_fail) begin
                        n_verdict = VERDICT_REDUCIBLE;
                        n_state   = ST_DONE;
                    end else if (irr_pass) begin
                        n_state = ST_POW_SQ;
                    end else begin
                        n_state = ST_IRR_GO;
                    end
                end
            end
            ST_POW_SQ: begin
                // squaring one gives one
                if (r_v == POLY_ONE) begin
                    n_state = ST_POW_X;
                end else begin
                    n_state = ST_POW_SQ_WAIT;
                end
            end
            ST_POW_SQ_WAIT: begin
                if (mul_done) begin
                    n_state = ST_POW_X;
                end
            end
            ST_POW_X: begin
                if (pow_last) begin
                    if (n_v == POLY_ONE) begin
                        n_verdict = VERDICT_IRREDUCIBLE;
                        n_state   = ST_DONE;
                    end else if (r_qi == Q_LAST) begin
                        n_verdict = VERDICT_PRIMITIVE;
                        n_state   = ST_DONE;
                    end else begin
                        n_state = ST_POW_SQ;
                    end
                end else begin
                    n_state = ST_POW_SQ;
                end
            end
            ST_DONE: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb begin
        busy      = 1'b1;
        o_valid   = 1'b0;
        mul_start = 1'b0;
        case (r_state)
            ST_IDLE: begin
                busy = 1'b0;
            end
            ST_IRR_GO: begin
                mul_start = 1'b1;
            end
            ST_POW_SQ: begin
                mul_start = (r_v != POLY_ONE);
            end
            ST_DONE: begin
                o_valid = 1'b1;
            end
            default: begin
                busy = 1'b1;
            end
        endcase
    end

    assign o_verdict = r_verdict;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_verdict <= VERDICT_REDUCIBLE;
        end else begin
            r_state   <= n_state;
            r_verdict <= n_verdict;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    r_tail <= i_candidate_low;
                    r_v    <= POLY_X;
                    r_k    <= K_W'(1);
                end
            end
            ST_IRR_WAIT: begin
                if (mul_done) begin
                    r_k <= r_k + K_W'(1);
                    if (irr_pass) begin
                        // start the first power from one
                        r_v   <= POLY_ONE;
                        r_qi  <= '0;
                        r_bit <= '1;
                    end else begin
                        r_v <= n_v;
                    end
                end
            end
            ST_POW_SQ_WAIT: begin
                r_v <= n_v;
            end
            ST_POW_X: begin
                if (pow_last) begin
                    r_v   <= POLY_ONE;
                    r_qi  <= r_qi + Q_IDX_W'(1);
                    r_bit <= '1;
                end else begin
                    r_v   <= n_v;
                    r_bit <= r_bit - BIT_IDX_W'(1);
                end
            end
            default: begin
                r_v <= r_v;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== tb/sv/gf2_poly64_primitivity_test_unit_tb.sv =====
// self-checking testbench for the degree-64 primitivity test unit with its own verdict predictor
`default_nettype none

module gf2_poly64_primitivity_test_unit_tb;

    localparam int CYCLE_LIMIT  = 6_000_000;
    localparam int RANDOM_ITEMS = 125;
    localparam int DRAIN_CYCLES = 40;

    localparam logic [63:0] Q_DIVISORS [7] = '{
        64'd3, 64'd5, 64'd17, 64'd257, 64'd641, 64'd65537, 64'd6700417
    };

    // eight degree-8 irreducibles; their product divides x^256 + x
    localparam logic [8:0] OCTIC_FACTORS [8] = '{
        9'h11B, 9'h11D, 9'h12B, 9'h12D, 9'h139, 9'h13F, 9'h14D, 9'h15F
    };

    logic        i_clk;
    logic        i_rst_n         = 1'b0;
    logic        start           = 1'b0;
    logic [63:0] i_candidate_low = '0;
    logic        busy;
    logic        o_valid;
    logic [1:0]  o_verdict;

    logic [63:0] candidates_pending [$];
    logic [1:0]  verdicts_expected [$];
    int          fail_count  = 0;
    int          cycle_count = 0;
    int          hold_cnt    = 0;
    int          calm_left   = 0;

    gf2_poly64_primitivity_test_unit dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_candidate_low (i_candidate_low),
        .o_valid         (o_valid),
        .o_verdict       (o_verdict)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // product modulo x^64 + tail, horner style from the top bit of b
    function automatic logic [63:0] fold_mul(input logic [63:0] a, input logic [63:0] b,
                                             input logic [63:0] tail);
        logic [63:0] acc;
        acc = '0;
        for (int i = 63; i >= 0; i--) begin
            acc = {acc[62:0], 1'b0} ^ (acc[63] ? tail : 64'd0);
            if (b[i]) acc ^= a;
        end
        return acc;
    endfunction

    function automatic logic [63:0] raise_power(input logic [63:0] base, input logic [63:0] e,
                                                input logic [63:0] tail);
        logic [63:0] acc;
        acc = 64'd1;
        while (e != 64'd0) begin
            if (e[0]) acc = fold_mul(acc, base, tail);
            base = fold_mul(base, base, tail);
            e    = e >> 1;
        end
        return acc;
    endfunction

    function automatic bit passes_irreducibility(input logic [63:0] tail);
        logic [63:0] v;
        v = 64'd2;
        for (int k = 1; k <= 64; k++) begin
            v = fold_mul(v, v, tail);
            // x^(2^k) == x for a proper divisor k means a factor of low degree
            if (k < 64 && (64 % k) == 0 && v == 64'd2) return 1'b0;
        end
        return v == 64'd2;
    endfunction

    function automatic logic [1:0] judge_candidate(input logic [63:0] tail);
        if (!passes_irreducibility(tail)) return gf2pt_pkg::VERDICT_REDUCIBLE;
        for (int i = 0; i < 7; i++) begin
            if (raise_power(64'd2, 64'hFFFF_FFFF_FFFF_FFFF / Q_DIVISORS[i], tail) == 64'd1)
                return gf2pt_pkg::VERDICT_IRREDUCIBLE;
        end
        return gf2pt_pkg::VERDICT_PRIMITIVE;
    endfunction

    function automatic logic [63:0] find_irreducible();
        logic [63:0] c;
        do begin
            c = {$urandom(), $urandom()} | 64'd1;
        end while (!passes_irreducibility(c));
        return c;
    endfunction

    always @(posedge i_clk) begin : driver
        bit take;
        int gap;
        if (!i_rst_n) begin
            start           <= 1'b0;
            i_candidate_low <= '0;
            hold_cnt = 0;
        end else begin
            take = start && !busy;
            if (take) begin
                verdicts_expected.push_back(judge_candidate(i_candidate_low));
                if (calm_left > 0) begin
                    gap = 0;
                    calm_left--;
                end else if ($urandom_range(0, 7) == 0) begin
                    gap = 0;
                    calm_left = $urandom_range(4, 12);
                end else begin
                    gap = $urandom_range(0, 4);
                end
                hold_cnt = gap;
            end
            if (!start || take) begin
                if (hold_cnt == 0 && candidates_pending.size() != 0) begin
                    start           <= 1'b1;
                    i_candidate_low <= candidates_pending.pop_front();
                end else begin
                    start <= 1'b0;
                    // the gap is counted from the point the unit goes idle
                    if (hold_cnt != 0 && !busy && !take) hold_cnt--;
                end
            end
        end
    end

    always @(posedge i_clk) begin : monitor
        logic [1:0] want;
        if (i_rst_n && o_valid) begin
            if (verdicts_expected.size() == 0) begin
                $error("verdict %0d arrived with no candidate outstanding", o_verdict);
                fail_count++;
            end else begin
                want = verdicts_expected.pop_front();
                if (o_verdict !== want) begin
                    $error("verdict: expected %0d, actual %0d", want, o_verdict);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin : watchdog
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL gf2_poly64_primitivity_test_unit");
            $finish;
        end
    end

    initial begin : stimulus
        logic [64:0] prod;
        logic [64:0] acc;
        logic [63:0] c;
        int          pick;
        int          a;
        int          b;

        // field extremes, zero constant terms and simple patterns
        candidates_pending.push_back(64'd0);
        candidates_pending.push_back(64'hFFFF_FFFF_FFFF_FFFF);
        candidates_pending.push_back(64'd1);
        candidates_pending.push_back(64'd2);
        candidates_pending.push_back(64'h0000_0000_0000_001B);
        candidates_pending.push_back(64'h8000_0000_0000_0000);
        candidates_pending.push_back(64'hFFFF_FFFF_FFFF_FFFE);
        candidates_pending.push_back(64'h8000_0000_0000_0001);
        candidates_pending.push_back(64'hAAAA_AAAA_AAAA_AAAA);
        candidates_pending.push_back(64'h5555_5555_5555_5555);

        // squarefree product of low-degree factors trips the early exit
        prod = 65'd1;
        for (int f = 0; f < 8; f++) begin
            acc = '0;
            for (int j = 0; j < 9; j++) begin
                if (OCTIC_FACTORS[f][j]) acc ^= prod << j;
            end
            prod = acc;
        end
        candidates_pending.push_back(prod[63:0]);

        // two of each irreducible verdict
        for (int n = 0; n < 2; n++) begin
            do c = find_irreducible();
            while (judge_candidate(c) != gf2pt_pkg::VERDICT_IRREDUCIBLE);
            candidates_pending.push_back(c);
            do c = find_irreducible();
            while (judge_candidate(c) != gf2pt_pkg::VERDICT_PRIMITIVE);
            candidates_pending.push_back(c);
        end

        // mostly irreducible candidates so the primitivity phase is exercised
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
                c = find_irreducible();
            end else if (pick < 75) begin
                c = {$urandom(), $urandom()};
            end else if (pick < 88) begin
                c = {$urandom(), $urandom()} & ~64'd1;
            end else begin
                a = $urandom_range(1, 63);
                b = $urandom_range(1, 63);
                c = (64'd1 << a) | (64'd1 << b) | 64'd1;
            end
            candidates_pending.push_back(c);
        end

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // sample between edges so the queues are settled
        do @(negedge i_clk);
        while (candidates_pending.size() != 0 || start);
        do @(negedge i_clk);
        while (verdicts_expected.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        if (fail_count == 0) begin
            $display("PASS gf2_poly64_primitivity_test_unit");
        end else begin
            $display("FAIL gf2_poly64_primitivity_test_unit");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ===== gf2_poly64_primitivity_test_unit.f =====
rtl/gf2pt_pkg.sv
rtl/gf2pt_mul.sv
rtl/gf2_poly64_primitivity_test_unit.sv
tb/sv/gf2_poly64_primitivity_test_unit_tb.sv
